// ----- hdl/frame_nearest_to_mean_select_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for frame nearest to mean select
// Implication checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FRAME_NEAREST_TO_MEAN_SELECT_TOP_ASSERT_SVH
`define FRAME_NEAREST_TO_MEAN_SELECT_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FNMS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame_nearest_to_mean_select_top: check failed");
// next-cycle implication
`define FNMS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame_nearest_to_mean_select_top: check failed");
`else
`define FNMS_ASSERT_IMP(lbl, ante, cons)
`define FNMS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- hdl/fnms_pkg.sv -----
// ----------------------------------------------------------------------------
// fnms_pkg
// Shared widths and control bundles of the frame nearest to mean selector.
// ----------------------------------------------------------------------------
package fnms_pkg;

	localparam int SAMPLE_W    = 8;
	localparam int DIST_W      = 18;
	localparam int FRAME_OUT_W = 2;
	localparam int TDATA_IN_W  = 8;
	localparam int TDATA_OUT_W = 24;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// one scoring read issued toward the score datapath
	typedef struct packed {
		logic valid;
		logic frame_last;
		logic set_last;
	} score_ctl_t;

	// winner of the last scoring pass
	typedef struct packed {
		logic                   ready;
		logic [FRAME_OUT_W-1:0] frame;
		logic [DIST_W-1:0]      distance;
	} score_res_t;

endpackage

// ----- hdl/frame_nearest_to_mean_select_top.sv -----
// ----------------------------------------------------------------------------
// frame_nearest_to_mean_select_top
// Picks the frame of a set that lies closest to the per-position mean frame.
// ----------------------------------------------------------------------------
// Samples arrive frame by frame, then channel, then pixel, one word per
// accepted transfer; tlast marks the final sample of the set. Each sample
// passes through an add state, where its position sum is read, added to and
// written back through the registered-read sum memory. The word carrying
// tlast then starts a scoring pass that reads every stored sample once, one
// per cycle, before the result word (winning frame, FRAMES times its summed
// absolute distance, saturated at 2^18-1) is offered; ties go to the earlier
// frame. After reset the sum memory is cleared before the first sample is
// taken. Samples beyond a full set are dropped from storage.
// ----------------------------------------------------------------------------
`include "frame_nearest_to_mean_select_top_assert.svh"

module frame_nearest_to_mean_select_top #(
	parameter int FRAMES             = 3,
	parameter int CHANNELS           = 3,
	parameter int PIXELS_PER_CHANNEL = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [fnms_pkg::TDATA_IN_W-1:0]   s_tdata,  // [7:0] sample
	input  logic                              s_tlast,  // last_sample
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [fnms_pkg::TDATA_OUT_W-1:0]  m_tdata   // [1:0] best_frame,
	                                                    // [19:2] best_distance
);
	import fnms_pkg::*;

	localparam int FRAME_SIZE = CHANNELS * PIXELS_PER_CHANNEL;
	localparam int SET_SIZE   = FRAMES * FRAME_SIZE;
	localparam int PAW        = (FRAME_SIZE > 1) ? $clog2(FRAME_SIZE) : 1;
	localparam int SAW        = $clog2(SET_SIZE);
	localparam int LCW        = $clog2(SET_SIZE + 1);
	localparam int FCW        = $clog2(FRAMES);
	localparam int SW         = $clog2(FRAMES * 255 + 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_ADD   = 3'd2;
	localparam logic [2:0] ST_SCORE = 3'd3;
	localparam logic [2:0] ST_WAIT  = 3'd4;

	logic [2:0]       state_q;
	logic [LCW-1:0]   load_cnt_q;
	logic [PAW-1:0]   pos_q;
	logic [SAW-1:0]   set_addr_q;
	logic [FCW-1:0]   frame_q;
	logic             store_s1;
	logic             last_s1;
	logic             clr_s1;
	logic [7:0]       sample_s1;
	logic [PAW-1:0]   wpos_s1;
	logic             accept;
	logic             store;
	logic             pos_wrap;
	logic             take;
	logic             sum_we;
	logic [PAW-1:0]   sum_waddr;
	logic [SW-1:0]    sum_wdata;
	logic [SW-1:0]    sum_rd;
	logic [7:0]       sample_rd;
	score_ctl_t       score_ctl;
	score_res_t       score_res;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign store    = (load_cnt_q < LCW'(SET_SIZE));
	assign pos_wrap = (pos_q == PAW'(FRAME_SIZE - 1));
	assign take     = (state_q == ST_WAIT) && score_res.ready && (!m_tvalid || m_tready);

	assign score_ctl.valid      = (state_q == ST_SCORE);
	assign score_ctl.frame_last = pos_wrap;
	assign score_ctl.set_last   = pos_wrap && (frame_q == FCW'(FRAMES - 1));

	always_comb begin
		case (state_q)
			ST_CLEAR: begin
				sum_we    = 1'b1;
				sum_waddr = pos_q;
				sum_wdata = '0;
			end
			ST_ADD: begin
				sum_we    = store_s1;
				sum_waddr = wpos_s1;
				sum_wdata = SW'(sum_rd + SW'(sample_s1));
			end
			default: begin
				// zero each sum behind its last-frame read
				sum_we    = clr_s1;
				sum_waddr = wpos_s1;
				sum_wdata = '0;
			end
		endcase
	end

	fnms_ram #(
		.WIDTH(8),
		.DEPTH(SET_SIZE)
	) u_sample_ram (
		.clk  (clk),
		.we   (accept && store),
		.waddr(load_cnt_q[SAW-1:0]),
		.wdata(s_tdata[7:0]),
		.raddr(set_addr_q),
		.rdata(sample_rd)
	);

	fnms_ram #(
		.WIDTH(SW),
		.DEPTH(FRAME_SIZE)
	) u_sum_ram (
		.clk  (clk),
		.we   (sum_we),
		.waddr(sum_waddr),
		.wdata(sum_wdata),
		.raddr(pos_q),
		.rdata(sum_rd)
	);

	fnms_score #(
		.FRAMES(FRAMES),
		.SW    (SW)
	) u_score (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (score_ctl),
		.sample_rd(sample_rd),
		.sum_rd   (sum_rd),
		.take     (take),
		.res      (score_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			load_cnt_q <= '0;
			pos_q      <= '0;
			set_addr_q <= '0;
			frame_q    <= '0;
			store_s1   <= 1'b0;
			last_s1    <= 1'b0;
			clr_s1     <= 1'b0;
			m_tvalid   <= 1'b0;
		end else begin
			clr_s1 <= 1'b0;
			if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					pos_q <= pos_wrap ? '0 : pos_q + 1'b1;
					if (pos_wrap) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						store_s1 <= store;
						last_s1  <= s_tlast;
						if (store) begin
							load_cnt_q <= load_cnt_q + 1'b1;
							pos_q      <= pos_wrap ? '0 : pos_q + 1'b1;
						end
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (last_s1) begin
						pos_q      <= '0;
						set_addr_q <= '0;
						frame_q    <= '0;
						state_q    <= ST_SCORE;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCORE: begin
					set_addr_q <= set_addr_q + 1'b1;
					pos_q      <= pos_wrap ? '0 : pos_q + 1'b1;
					clr_s1     <= (frame_q == FCW'(FRAMES - 1));
					if (pos_wrap) begin
						frame_q <= frame_q + 1'b1;
					end
					if (score_ctl.set_last) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (take) begin
						m_tvalid   <= 1'b1;
						load_cnt_q <= '0;
						pos_q      <= '0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= s_tdata[7:0];
		end
		wpos_s1 <= pos_q;
		if (take) begin
			m_tdata <= {{(TDATA_OUT_W - DIST_W - FRAME_OUT_W){1'b0}},
				score_res.distance, score_res.frame};
		end
	end

	// a clearing write must never land on the entry being read this cycle
	`FNMS_ASSERT_IMP(a_no_sum_clash, sum_we && state_q == ST_SCORE, sum_waddr != pos_q)
	`FNMS_ASSERT_NXT(a_take_rearms, take, load_cnt_q == '0 && pos_q == '0 && m_tvalid)
	`FNMS_ASSERT_IMP(a_frame_range, state_q == ST_SCORE, frame_q <= FCW'(FRAMES - 1))

endmodule

// ----- hdl/fnms_ram.sv -----
// ----------------------------------------------------------------------------
// fnms_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fnms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/fnms_score.sv -----
// ----------------------------------------------------------------------------
// fnms_score
// Scoring datapath: scaled absolute difference, saturating frame total and
// running minimum over frames.
// ----------------------------------------------------------------------------
module fnms_score #(
	parameter int FRAMES = 3,
	parameter int SW     = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fnms_pkg::score_ctl_t  ctl,
	input  logic [7:0]            sample_rd,
	input  logic [SW-1:0]         sum_rd,
	input  logic                  take,
	output fnms_pkg::score_res_t  res
);
	import fnms_pkg::*;

	localparam int FCW = $clog2(FRAMES);

	score_ctl_t        ctl_s1;
	score_ctl_t        ctl_s2;
	logic [SW-1:0]     diff_s2;
	logic [SW-1:0]     scaled;
	logic [SW-1:0]     diff;
	logic [DIST_W-1:0] acc_q;
	logic [DIST_W:0]   sum_ext;
	logic [DIST_W-1:0] acc_sat;
	logic [FCW-1:0]    frame_q;
	logic [FCW-1:0]    best_frame_q;
	logic [DIST_W-1:0] best_dist_q;
	logic              ready_q;
	logic [FCW+1:0]    frame_ext;

	assign scaled  = SW'(FRAMES) * SW'(sample_rd);
	assign diff    = (scaled >= sum_rd) ? (scaled - sum_rd) : (sum_rd - scaled);
	assign sum_ext = {1'b0, acc_q} + (DIST_W+1)'(diff_s2);
	assign acc_sat = (sum_ext > {1'b0, DIST_MAX}) ? DIST_MAX : sum_ext[DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1       <= '0;
			ctl_s2       <= '0;
			acc_q        <= '0;
			frame_q      <= '0;
			best_frame_q <= '0;
			best_dist_q  <= '0;
			ready_q      <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			if (take) begin
				ready_q <= 1'b0;
			end
			if (ctl_s2.valid) begin
				if (ctl_s2.frame_last) begin
					// first frame always seeds the minimum; ties keep the earlier frame
					if (frame_q == '0 || acc_sat < best_dist_q) begin
						best_dist_q  <= acc_sat;
						best_frame_q <= frame_q;
					end
					acc_q   <= '0;
					frame_q <= ctl_s2.set_last ? '0 : frame_q + 1'b1;
					if (ctl_s2.set_last) begin
						ready_q <= 1'b1;
					end
				end else begin
					acc_q <= acc_sat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		diff_s2 <= diff;
	end

	assign frame_ext    = {2'b00, best_frame_q};
	assign res.ready    = ready_q;
	assign res.frame    = frame_ext[FRAME_OUT_W-1:0];
	assign res.distance = best_dist_q;

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame nearest to mean selector.
// ----------------------------------------------------------------------------
// Streams frame sets into the selector and predicts each result word by
// scoring every frame against the per-position sums. Samples past a full
// set are dropped, and short sets reuse what an earlier set stored. The
// first set is full so that every stored sample is written before any short
// set reads it. The sample and result sides idle and stall at random, phase
// by phase, and each result word is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import fnms_pkg::*;

	localparam int FRAMES       = 3;
	localparam int CHANNELS     = 3;
	localparam int PIXELS       = 64;
	localparam int FRAME_SIZE   = CHANNELS * PIXELS;
	localparam int SET_SIZE     = FRAMES * FRAME_SIZE;
	localparam int SCORE_CYCLES = SET_SIZE + 4;
	localparam int QUIET_LIMIT  = 4000;
	localparam int PHASE_WORDS  = 190;

	typedef struct packed {
		logic [FRAME_OUT_W-1:0] frame;
		logic [DIST_W-1:0]      distance;
	} pick_t;

	logic                   clk;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata  = '0;  // [7:0] sample
	logic                   s_tlast  = 1'b0;  // last_sample
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;  // [1:0] best_frame, [19:2] best_distance

	// predictor state
	logic [SAMPLE_W-1:0] stored_samples [SET_SIZE];
	logic [9:0]          position_total [FRAME_SIZE] = '{default: '0};
	int unsigned         fill_count = 0;
	pick_t               pending_picks [$];

	int unsigned mismatch_count = 0;
	int unsigned sent_count     = 0;
	int unsigned idle_pct       = 0;
	int unsigned stall_pct      = 0;
	int unsigned quiet_cycles   = 0;

	frame_nearest_to_mean_select_top #(
		.FRAMES             (FRAMES),
		.CHANNELS           (CHANNELS),
		.PIXELS_PER_CHANNEL (PIXELS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// FRAMES times the summed absolute distance of one frame from the mean
	function automatic logic [DIST_W-1:0] frame_distance(int unsigned f);
		int unsigned acc;
		int unsigned scaled;
		int unsigned total;
		int unsigned p;
		acc = 0;
		for (p = 0; p < FRAME_SIZE; p++) begin
			scaled = FRAMES * stored_samples[f * FRAME_SIZE + p];
			total  = position_total[p];
			acc += (scaled >= total) ? scaled - total : total - scaled;
			if (acc > DIST_MAX)
				return DIST_MAX;
		end
		return acc[DIST_W-1:0];
	endfunction

	task automatic record_sample(logic [SAMPLE_W-1:0] smp, logic last);
		pick_t             best;
		logic [DIST_W-1:0] d;
		int unsigned       f;
		if (fill_count < SET_SIZE) begin
			stored_samples[fill_count] = smp;
			position_total[fill_count % FRAME_SIZE] += smp;
			fill_count++;
		end
		if (last) begin
			best.frame    = '0;
			best.distance = frame_distance(0);
			for (f = 1; f < FRAMES; f++) begin
				d = frame_distance(f);
				// strict compare: a tie keeps the earlier frame
				if (d < best.distance) begin
					best.distance = d;
					best.frame    = FRAME_OUT_W'(f);
				end
			end
			pending_picks.push_back(best);
			position_total = '{default: '0};
			fill_count     = 0;
		end
	endtask

	task automatic report_mismatch(string what);
		mismatch_count++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	task automatic send_sample(logic [SAMPLE_W-1:0] smp, logic last);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent_count++;
		record_sample(smp, last);
	endtask

	task automatic send_random_set(int unsigned len);
		int unsigned i;
		for (i = 0; i < len; i++)
			send_sample(SAMPLE_W'($urandom_range(0, 255)), i == len - 1);
	endtask

	// full set with frames 0 and 1 equal and frame 2 far off, so the first
	// two tie; a few extra samples follow and the last of them ends the set
	task automatic test_full_tie_set_with_extras();
		logic [SAMPLE_W-1:0] base [FRAME_SIZE];
		int unsigned         extras;
		int unsigned         i;
		int unsigned         p;
		idle_pct  = 6;
		stall_pct = 6;
		extras    = $urandom_range(1, 8);
		for (p = 0; p < FRAME_SIZE; p++)
			base[p] = SAMPLE_W'($urandom_range(0, 255));
		for (i = 0; i < SET_SIZE + extras; i++) begin
			p = i % FRAME_SIZE;
			if (i >= SET_SIZE)
				send_sample(SAMPLE_W'($urandom_range(0, 255)), i == SET_SIZE + extras - 1);
			else if (i < 2 * FRAME_SIZE)
				send_sample(base[p], 1'b0);
			else
				send_sample(base[p] ^ 8'h80, 1'b0);
		end
	endtask

	task automatic test_short_set_extremes();
		idle_pct  = 0;
		stall_pct = 0;
		send_sample(8'h00, 1'b1);
		send_sample(8'hFF, 1'b1);
		send_sample(8'h55, 1'b0);
		send_sample(8'hAA, 1'b0);
		send_sample(8'hFF, 1'b1);
		send_sample(8'h01, 1'b0);
		send_sample(8'h80, 1'b0);
		send_sample(8'h7F, 1'b0);
		send_sample(8'hFE, 1'b1);
		send_sample(8'hFF, 1'b0);
		send_sample(8'h00, 1'b1);
	endtask

	task automatic test_random_sets();
		int unsigned idle_by_phase [4]  = '{0, 61, 0, 6};
		int unsigned stall_by_phase [4] = '{0, 0, 61, 6};
		int unsigned phase;
		int unsigned phase_start;
		int unsigned len;
		for (phase = 0; phase < 4; phase++) begin
			idle_pct    = idle_by_phase[phase];
			stall_pct   = stall_by_phase[phase];
			phase_start = sent_count;
			while (sent_count - phase_start < PHASE_WORDS) begin
				// mostly sets of 1 to 12 samples, now and then a longer one of 13 to 250
				if ($urandom_range(0, 99) < 90)
					len = $urandom_range(1, 12);
				else
					len = $urandom_range(13, 250);
				send_random_set(len);
			end
		end
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= stall_pct);

	always @(posedge clk) begin
		pick_t got;
		pick_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.frame    = m_tdata[FRAME_OUT_W-1:0];
			got.distance = m_tdata[FRAME_OUT_W +: DIST_W];
			if (pending_picks.size() == 0) begin
				report_mismatch($sformatf("unexpected word: frame %0d distance %0d",
					got.frame, got.distance));
			end else begin
				want = pending_picks.pop_front();
				if (got.frame !== want.frame)
					report_mismatch($sformatf("best_frame %0d, predicted %0d",
						got.frame, want.frame));
				if (got.distance !== want.distance)
					report_mismatch($sformatf("best_distance %0d, predicted %0d",
						got.distance, want.distance));
			end
		end
	end

	// end the run when neither side moves a word for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_full_tie_set_with_extras();
		test_short_set_extremes();
		test_random_sets();
		s_tvalid  <= 1'b0;
		stall_pct = 0;
		while (pending_picks.size() != 0)
			@(posedge clk);
		// hold long enough for a stray result word to show up
		repeat (SCORE_CYCLES + 20) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
